// ----- src/elastic_easing_curve_assert.svh -----
// Assertion macros for the elastic easing curve block.
// Depends on clk_i and rst_ni being in scope where a macro is used.
`ifndef ELASTIC_EASING_CURVE_ASSERT_SVH
`define ELASTIC_EASING_CURVE_ASSERT_SVH
// Check a property on the rising clock, off while in reset.
`define EEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on the rising clock, also while in reset.
`define EEC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

// ----- src/eec_pkg.sv -----
// Shared constants, types and elaboration-time tables for the easing curve.
// No dependencies; used by every module of the block.
package eec_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_LEN        = (1 << SINE_TABLE_BITS) + 1;
  localparam int SINE_IDX_W      = SINE_TABLE_BITS + 1;
  localparam int PHASE_FRAC      = 32 - SINE_TABLE_BITS;
  localparam int QB              = SINE_TABLE_BITS - 2;
  localparam int X_W             = FRAC_BITS + 1;
  localparam int Y_W             = FRAC_BITS + 2;
  localparam int N_W             = 26;
  localparam int A_W             = 20;
  localparam int EXP_TERMS       = 12;

  localparam int FRONT_LAT = 1;
  localparam int SINE_LAT  = 6;
  localparam int EXP_LAT   = 1 + 3 * EXP_TERMS;
  localparam int SCALE_LAT = 3;
  localparam int TOTAL_LAT = FRONT_LAT + EXP_LAT + SCALE_LAT;
  localparam int S_DLY     = EXP_LAT - SINE_LAT;

  localparam logic [1:0] MODE_IN    = 2'd0;
  localparam logic [1:0] MODE_OUT   = 2'd1;
  localparam logic [1:0] MODE_INOUT = 2'd2;

  localparam logic [X_W-1:0]        X_ONE = X_W'(1 << FRAC_BITS);
  localparam logic signed [N_W-1:0] ONE_S = N_W'(1 << FRAC_BITS);
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [29:0] LN2_Q30     = 30'd744261118;

  typedef struct packed {
    logic       is_zero;
    logic       is_one;
    logic       neg;
    logic       add_one;
    logic       extra;
    logic       fz;
    logic [3:0] sh;
  } ctl_t;

  typedef logic signed [31:0] sine_rom_t [SINE_LEN];

  function automatic logic [63:0] quarter_sine(input logic [63:0] theta);
    logic [63:0] t2;
    logic [63:0] r;
    t2 = (theta * theta) >> 30;
    r  = Q30_ONE;
    r  = Q30_ONE - (((t2 * r) >> 30) / 64'd156);
    r  = Q30_ONE - (((t2 * r) >> 30) / 64'd110);
    r  = Q30_ONE - (((t2 * r) >> 30) / 64'd72);
    r  = Q30_ONE - (((t2 * r) >> 30) / 64'd42);
    r  = Q30_ONE - (((t2 * r) >> 30) / 64'd20);
    r  = Q30_ONE - (((t2 * r) >> 30) / 64'd6);
    return (theta * r) >> 30;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    logic [63:0]     th;
    logic [63:0]     s;
    logic [1:0]      q;
    logic [QB-1:0]   rr;
    logic [QB:0]     pos;
    for (int k = 0; k < SINE_LEN; k++) begin
      q   = 2'(k >> QB);
      rr  = QB'(k);
      pos = q[0] ? (QB+1)'((1 << QB) - int'(rr)) : {1'b0, rr};
      th  = (64'(pos) * HALF_PI_Q30) >> QB;
      s   = quarter_sine(th);
      rom[k] = q[1] ? -$signed(32'(s)) : $signed(32'(s));
    end
    return rom;
  endfunction

  function automatic logic [31:0] exp_recip(input int k);
    logic [31:0] r;
    case (k)
      2:       r = 32'd2147483648;
      3:       r = 32'd1431655765;
      4:       r = 32'd1073741824;
      5:       r = 32'd858993459;
      6:       r = 32'd715827882;
      7:       r = 32'd613566756;
      8:       r = 32'd536870912;
      9:       r = 32'd477218588;
      10:      r = 32'd429496729;
      11:      r = 32'd390451572;
      12:      r = 32'd357913941;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/elastic_easing_curve.sv -----
// Elastic easing curve top level: config register, valid line, stage wiring.
// Depends on eec_pkg, eec_front, eec_sine, eec_exp, eec_scale and the assert header.
//
// Usage:
//  - Input channel in_valid_i/in_ready_o carries progress_i, unsigned Q1.16;
//    values above 1.0 saturate to 1.0.
//  - Output channel out_valid_o/out_ready_i carries eased_value_o, signed Q2.16.
//  - cfg_we_i writes cfg_wdata_i into the curve select (0 in, 1 out, 2 or 3
//    in-out); write only while the pipeline is empty.
//  - One beat enters per cycle while in_ready_o is high. Depth is set by the
//    twelve-term exp Taylor chain, three stages per term, plus decode, the ln2
//    stage and three scaling stages.
//  - All stages share one advance enable. A stalled receiver holds the whole
//    pipeline only while the final stage holds a result; bubbles still drain.
//  - Reset empties the valid line and sets the curve select to ease-in.
//    There is no clearing pass; the sine ROM is constant.
module elastic_easing_curve (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [eec_pkg::X_W-1:0]       progress_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [eec_pkg::Y_W-1:0]       eased_value_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_wdata_i
);

  `include "elastic_easing_curve_assert.svh"

  localparam int LAT = eec_pkg::TOTAL_LAT;
  localparam int CTL_DLY = eec_pkg::EXP_LAT;

  logic [1:0]                       mode_q;
  logic [LAT-1:0]                   vld_q;
  logic                             en;
  logic signed [eec_pkg::N_W-1:0]   n;
  logic                             c9;
  logic [eec_pkg::FRAC_BITS-1:0]    f;
  eec_pkg::ctl_t                    ctl;
  eec_pkg::ctl_t                    ctl_dly_q [CTL_DLY];
  logic signed [31:0]               s;
  logic signed [31:0]               s_dly_q [eec_pkg::S_DLY];
  logic [31:0]                      mant;

  assign en          = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= eec_pkg::MODE_IN;
      vld_q  <= '0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (en) vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  eec_front u_front (
    .clk_i      (clk_i),
    .en_i       (en),
    .progress_i (progress_i),
    .mode_i     (mode_q),
    .n_o        (n),
    .c9_o       (c9),
    .f_o        (f),
    .ctl_o      (ctl)
  );

  eec_sine u_sine (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (n),
    .c9_i  (c9),
    .s_o   (s)
  );

  eec_exp u_exp (
    .clk_i  (clk_i),
    .en_i   (en),
    .f_i    (f),
    .mant_o (mant)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_dly_q[0] <= ctl;
      for (int i = 1; i < CTL_DLY; i++) ctl_dly_q[i] <= ctl_dly_q[i-1];
      s_dly_q[0] <= s;
      for (int i = 1; i < eec_pkg::S_DLY; i++) s_dly_q[i] <= s_dly_q[i-1];
    end
  end

  eec_scale u_scale (
    .clk_i  (clk_i),
    .en_i   (en),
    .s_i    (s_dly_q[eec_pkg::S_DLY-1]),
    .mant_i (mant),
    .ctl_i  (ctl_dly_q[CTL_DLY-1]),
    .y_o    (eased_value_o)
  );

  `EEC_ASSERT(a_stall_hold, !en |=> $stable(vld_q), "valid line moved while stalled")
  `EEC_ASSERT(a_enter, in_valid_i && in_ready_o |=> vld_q[0], "accepted beat missing")
  `EEC_ASSERT_RST(a_rst_empty, !rst_ni |=> (vld_q == '0), "pipeline not empty in reset")

endmodule

// ----- src/eec_front.sv -----
// Input decode stage: saturate progress, pick curve terms and exponent.
// Depends on eec_pkg.
module eec_front (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [eec_pkg::X_W-1:0]             progress_i,
  input  logic [1:0]                          mode_i,
  output logic signed [eec_pkg::N_W-1:0]      n_o,
  output logic                                c9_o,
  output logic [eec_pkg::FRAC_BITS-1:0]       f_o,
  output eec_pkg::ctl_t                       ctl_o
);

  logic [eec_pkg::X_W-1:0]        x;
  logic signed [eec_pkg::N_W-1:0] xs;
  logic signed [eec_pkg::N_W-1:0] n_d;
  logic signed [eec_pkg::N_W-1:0] a_s;
  logic [eec_pkg::A_W-1:0]        a;
  logic                           c9_d;
  eec_pkg::ctl_t                  ctl_d;

  always_comb begin
    x  = (progress_i > eec_pkg::X_ONE) ? eec_pkg::X_ONE : progress_i;
    xs = $signed({{(eec_pkg::N_W-eec_pkg::X_W){1'b0}}, x});
    ctl_d = '0;
    if (mode_i[1]) begin
      c9_d = 1'b1;
      n_d  = xs * 26'sd160 - 26'sd89 * eec_pkg::ONE_S;
      ctl_d.extra = 1'b1;
      if (x < (eec_pkg::X_ONE >> 1)) begin
        a_s = 26'sd10 * eec_pkg::ONE_S - 26'sd20 * xs;
        ctl_d.neg = 1'b1;
      end else begin
        a_s = 26'sd20 * xs - 26'sd10 * eec_pkg::ONE_S;
        ctl_d.add_one = 1'b1;
      end
    end else if (mode_i == eec_pkg::MODE_OUT) begin
      c9_d = 1'b0;
      n_d  = xs * 26'sd40 - 26'sd3 * eec_pkg::ONE_S;
      a_s  = 26'sd10 * xs;
      ctl_d.add_one = 1'b1;
    end else begin
      c9_d = 1'b0;
      n_d  = xs * 26'sd40 - 26'sd43 * eec_pkg::ONE_S;
      a_s  = 26'sd10 * eec_pkg::ONE_S - 26'sd10 * xs;
      ctl_d.neg = 1'b1;
    end
    a = a_s[eec_pkg::A_W-1:0];
    ctl_d.is_zero = (x == '0);
    ctl_d.is_one  = (x == eec_pkg::X_ONE);
    ctl_d.fz      = (a[eec_pkg::FRAC_BITS-1:0] == '0);
    ctl_d.sh      = a[eec_pkg::A_W-1:eec_pkg::FRAC_BITS] + {3'b0, !ctl_d.fz};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o   <= n_d;
      c9_o  <= c9_d;
      f_o   <= a[eec_pkg::FRAC_BITS-1:0];
      ctl_o <= ctl_d;
    end
  end

endmodule

// ----- src/eec_sine.sv -----
// Phase reduction and interpolated sine lookup, six register stages.
// Depends on eec_pkg for the sine ROM and widths.
module eec_sine (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [eec_pkg::N_W-1:0] n_i,
  input  logic                           c9_i,
  output logic signed [31:0]             s_o
);

  localparam eec_pkg::sine_rom_t SINE_ROM = eec_pkg::build_sine_rom();
  localparam logic [13:0] L3 [3] = '{14'd0, 14'((16384 + 1) / 3), 14'((2 * 16384 + 1) / 3)};
  localparam logic [13:0] L9 [9] = '{14'd0, 14'((16384 + 4) / 9), 14'((2 * 16384 + 4) / 9),
                                     14'((3 * 16384 + 4) / 9), 14'((4 * 16384 + 4) / 9),
                                     14'((5 * 16384 + 4) / 9), 14'((6 * 16384 + 4) / 9),
                                     14'((7 * 16384 + 4) / 9), 14'((8 * 16384 + 4) / 9)};

  logic signed [7:0] nh;
  logic [6:0]        v;
  logic [6:0]        cw;
  logic [21:0]       m_d;
  logic [21:0]       m1_q;
  logic              c9_1_q;
  logic [22:0]       rc;
  logic [45:0]       qp;
  logic [17:0]       q0_q;
  logic [21:0]       m2_q;
  logic              c9_2_q;
  logic [3:0]        c2;
  logic [21:0]       rem;
  logic [17:0]       h;
  logic [3:0]        l;
  logic [13:0]       frac;
  logic [31:0]       phase_q;
  logic [eec_pkg::SINE_TABLE_BITS-1:0] idx;
  logic [eec_pkg::SINE_IDX_W-1:0]      idx_p1;
  logic signed [31:0] a_q;
  logic signed [31:0] b_q;
  logic [eec_pkg::PHASE_FRAC-1:0] fr_q;
  logic signed [55:0] prod_q;
  logic signed [31:0] a2_q;

  always_comb begin
    nh = n_i[eec_pkg::N_W-1:18];
    v  = 7'(nh + 8'sd27);
    cw = c9_i ? 7'd9 : 7'd3;
    for (int i = 3; i >= 0; i--) begin
      if (v >= 7'(cw << i)) v = v - 7'(cw << i);
    end
    m_d = {v[3:0], n_i[17:0]};
  end

  always_comb begin
    rc = c9_1_q ? 23'd1864135 : 23'd5592405;
    qp = 46'(m1_q) * 46'(rc);
  end

  always_comb begin
    c2  = c9_2_q ? 4'd9 : 4'd3;
    rem = m2_q - 22'(q0_q) * 22'(c2);
    if (rem >= 22'(c2)) begin
      h = q0_q + 18'd1;
      l = 4'(rem - 22'(c2));
    end else begin
      h = q0_q;
      l = 4'(rem);
    end
    frac = c9_2_q ? L9[l] : L3[l[1:0]];
  end

  assign idx    = phase_q[31:eec_pkg::PHASE_FRAC];
  assign idx_p1 = {1'b0, idx} + eec_pkg::SINE_IDX_W'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q    <= m_d;
      c9_1_q  <= c9_i;
      q0_q    <= 18'(qp >> 24);
      m2_q    <= m1_q;
      c9_2_q  <= c9_1_q;
      phase_q <= {h, frac};
      a_q     <= SINE_ROM[{1'b0, idx}];
      b_q     <= SINE_ROM[idx_p1];
      fr_q    <= phase_q[eec_pkg::PHASE_FRAC-1:0];
      prod_q  <= 56'(33'(b_q) - 33'(a_q)) * $signed({34'b0, fr_q});
      a2_q    <= a_q;
      s_o     <= a2_q + 32'(prod_q >>> eec_pkg::PHASE_FRAC);
    end
  end

endmodule

// ----- src/eec_exp.sv -----
// Exp2 mantissa: ln2 scaling then a twelve-term Taylor chain, three stages a term.
// Depends on eec_pkg for constants and reciprocals.
module eec_exp (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [eec_pkg::FRAC_BITS-1:0] f_i,
  output logic [31:0]                   mant_o
);

  localparam int NT = eec_pkg::EXP_TERMS;

  logic [29:0] z_q;
  logic [29:0] za_q [NT-1];
  logic [29:0] zb_q [NT-1];
  logic [29:0] zc_q [NT-1];
  logic [31:0] pa_q [NT];
  logic [31:0] pb_q [NT];
  logic [31:0] qb_q [NT];
  logic [31:0] r_q  [NT];
  logic [29:0] z_in [NT];
  logic [31:0] r_in [NT];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q <= 30'((47'(eec_pkg::X_ONE - {1'b0, f_i}) * 47'(eec_pkg::LN2_Q30))
                 >> eec_pkg::FRAC_BITS);
    end
  end

  for (genvar j = 0; j < NT; j++) begin : g_term
    localparam int K = NT - j;
    logic [31:0] rem;
    logic [31:0] qc;

    if (j == 0) begin : g_first
      assign z_in[j] = z_q;
      assign r_in[j] = 32'(eec_pkg::Q30_ONE);
    end else begin : g_next
      assign z_in[j] = zc_q[j-1];
      assign r_in[j] = r_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_q[j] <= 32'((62'(z_in[j]) * 62'(r_in[j])) >> 30);
        pb_q[j] <= pa_q[j];
        r_q[j]  <= 32'(eec_pkg::Q30_ONE) + qc;
      end
    end

    if (K == 1) begin : g_unit
      always_ff @(posedge clk_i) begin
        if (en_i) qb_q[j] <= pa_q[j];
      end
    end else begin : g_recip
      localparam logic [31:0] RECIP = eec_pkg::exp_recip(K);
      always_ff @(posedge clk_i) begin
        if (en_i) qb_q[j] <= 32'((64'(pa_q[j]) * 64'(RECIP)) >> 32);
      end
    end

    always_comb begin
      rem = pb_q[j] - qb_q[j] * 32'(K);
      qc  = (rem >= 32'(K)) ? qb_q[j] + 32'd1 : qb_q[j];
    end

    if (j < NT - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          za_q[j] <= z_in[j];
          zb_q[j] <= za_q[j];
          zc_q[j] <= zb_q[j];
        end
      end
    end
  end

  assign mant_o = r_q[NT-1];

endmodule

// ----- src/eec_scale.sv -----
// Output stages: sine times mantissa, rounding shift, sign and offset.
// Depends on eec_pkg for the control struct and widths.
module eec_scale (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [31:0]          s_i,
  input  logic [31:0]                 mant_i,
  input  eec_pkg::ctl_t               ctl_i,
  output logic [eec_pkg::Y_W-1:0]     y_o
);

  logic [31:0]          mant_e;
  logic [31:0]          abs_s;
  logic [62:0]          mag_q;
  logic                 sneg_a_q;
  eec_pkg::ctl_t        ctl_a_q;
  logic [5:0]           t;
  logic [63:0]          sum;
  logic [18:0]          r_q;
  logic                 sneg_b_q;
  eec_pkg::ctl_t        ctl_b_q;
  logic signed [19:0]   term;
  logic signed [19:0]   v;

  always_comb begin
    mant_e = ctl_i.fz ? 32'(eec_pkg::Q30_ONE) : mant_i;
    abs_s  = s_i[31] ? 32'(-s_i) : 32'(s_i);
  end

  always_comb begin
    t   = 6'(60 - eec_pkg::FRAC_BITS) + {2'b0, ctl_a_q.sh} + {5'b0, ctl_a_q.extra};
    sum = 64'(mag_q) + (64'd1 << (t - 6'd1));
  end

  always_comb begin
    term = sneg_b_q ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    if (ctl_b_q.is_zero) begin
      v = '0;
    end else if (ctl_b_q.is_one) begin
      v = 20'(eec_pkg::X_ONE);
    end else if (ctl_b_q.neg) begin
      v = -term;
    end else begin
      v = term + 20'(eec_pkg::X_ONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q    <= 63'(abs_s[30:0]) * 63'(mant_e);
      sneg_a_q <= s_i[31];
      ctl_a_q  <= ctl_i;
      r_q      <= 19'(sum >> t);
      sneg_b_q <= sneg_a_q;
      ctl_b_q  <= ctl_a_q;
      y_o      <= v[eec_pkg::Y_W-1:0];
    end
  end

endmodule
